// File: src/abit_pkg.sv
// Shared types, codes and handshake structs for the array binary search tree block.
package abit_pkg;

	// Operation codes carried by an input item.
	localparam logic [1:0] OP_INSERT    = 2'd0;
	localparam logic [1:0] OP_INORDER   = 2'd1;
	localparam logic [1:0] OP_PREORDER  = 2'd2;
	localparam logic [1:0] OP_POSTORDER = 2'd3;

	// Status codes carried by a result item.
	localparam logic [1:0] ST_VALUE    = 2'd0;
	localparam logic [1:0] ST_INSERTED = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_EMPTY    = 2'd3;

	// Width of a stored key.
	localparam int KEY_W = 32;

	typedef struct packed {
		logic [1:0]              op;
		logic signed [KEY_W-1:0] key_value;
	} item_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] node_out;
		logic [1:0]              status;
		logic                    last;
	} result_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_INS_CHK,
		S_INS_CMP,
		S_VISIT,
		S_EMIT,
		S_MOVE,
		S_FLUSH
	} state_t;

	// Phase of the walk at the current node: just arrived, left subtree done,
	// right subtree done.
	typedef enum logic [1:0] {
		DIR_DOWN,
		DIR_LEFT_DONE,
		DIR_RIGHT_DONE
	} dir_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic ins_read;
		logic ins_write;
		logic ins_descend;
		logic emit_read;
		logic emit_take;
		logic move;
		logic flush;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic item_insert;
		logic cur_live;
		logic empty_root;
		logic emit_now;
		logic trav_done;
		logic pend_vld;
		logic out_free;
	} sts_t;

endpackage

// File: src/abit_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module abit_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 63
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/abit_datapath.sv
// Datapath: slot store, valid bits, walk position, hold buffer and result register.
module abit_datapath #(
	parameter int TREE_SLOTS = 63
) (
	input  logic             clk,
	input  logic             arst_n,
	input  abit_pkg::cmd_t   cmd,
	output abit_pkg::sts_t   sts,
	input  abit_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_stall,
	output abit_pkg::result_t result
);

	localparam int IDX_W  = (TREE_SLOTS > 1) ? $clog2(TREE_SLOTS) : 1;
	localparam int NODE_W = $clog2(2 * TREE_SLOTS + 1);
	localparam logic [NODE_W-1:0] SLOTS_N = NODE_W'(TREE_SLOTS);
	localparam logic [NODE_W-1:0] ONE_N   = NODE_W'(1);
	localparam logic [NODE_W-1:0] TWO_N   = NODE_W'(2);

	logic [1:0]                        op_q;
	logic signed [abit_pkg::KEY_W-1:0] key_q;
	logic [NODE_W-1:0]                 idx_q;
	abit_pkg::dir_t                    dir_q;
	logic [TREE_SLOTS-1:0]             valid_q;
	logic [abit_pkg::KEY_W-1:0]        pend_q;
	logic                              pend_vld_q;
	logic [1:0]                        res_status_q;
	abit_pkg::result_t                 out_q;
	logic                              out_vld_q;

	logic [NODE_W-1:0]          left_idx;
	logic [NODE_W-1:0]          right_idx;
	logic [NODE_W-1:0]          parent_idx;
	logic                       cur_live;
	logic                       left_live;
	logic                       right_live;
	logic                       in_range;
	logic                       ram_we;
	logic                       ram_re;
	logic [abit_pkg::KEY_W-1:0] ram_rdata;
	logic                       out_free;
	logic                       out_load;
	logic                       emit_now;

	// A slot is live when it lies inside the array and holds a value.
	function automatic logic slot_live(input logic [NODE_W-1:0] n,
			input logic [TREE_SLOTS-1:0] v);
		slot_live = (n < SLOTS_N) && v[n[IDX_W-1:0]];
	endfunction

	// Neighbours of the current slot under implicit heap indexing.
	assign left_idx   = {idx_q[NODE_W-2:0], 1'b1};
	assign right_idx  = {idx_q[NODE_W-2:0], 1'b0} + TWO_N;
	assign parent_idx = (idx_q - ONE_N) >> 1;

	assign in_range   = idx_q < SLOTS_N;
	assign cur_live   = slot_live(idx_q, valid_q);
	assign left_live  = slot_live(left_idx, valid_q);
	assign right_live = slot_live(right_idx, valid_q);

	// The order code decides in which phase of a node its value is emitted.
	always_comb begin
		case (dir_q)
			abit_pkg::DIR_DOWN:       emit_now = (op_q == abit_pkg::OP_PREORDER);
			abit_pkg::DIR_LEFT_DONE:  emit_now = (op_q == abit_pkg::OP_INORDER);
			abit_pkg::DIR_RIGHT_DONE: emit_now = (op_q == abit_pkg::OP_POSTORDER);
			default:                  emit_now = 1'b0;
		endcase
	end

	assign out_free = !out_vld_q || !result_stall;

	// Status towards the controller.
	always_comb begin
		sts.item_insert = (item.op == abit_pkg::OP_INSERT);
		sts.cur_live    = cur_live;
		sts.empty_root  = (dir_q == abit_pkg::DIR_DOWN) && !cur_live;
		sts.emit_now    = emit_now;
		sts.trav_done   = (dir_q == abit_pkg::DIR_RIGHT_DONE) && (idx_q == '0);
		sts.pend_vld    = pend_vld_q;
		sts.out_free    = out_free;
	end

	// Slot store.
	assign ram_we = cmd.ins_write && in_range;
	assign ram_re = cmd.ins_read || cmd.emit_read;

	abit_ram #(
		.WIDTH(abit_pkg::KEY_W),
		.DEPTH(TREE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q[IDX_W-1:0]),
		.wdata(key_q),
		.re   (ram_re),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Latched item and the result status of an insert.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= item.op;
			key_q <= item.key_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_status_q <= abit_pkg::ST_EMPTY;
		end else if (cmd.accept) begin
			res_status_q <= abit_pkg::ST_EMPTY;
		end else if (cmd.ins_write) begin
			res_status_q <= in_range ? abit_pkg::ST_INSERTED : abit_pkg::ST_FULL;
		end
	end

	// Valid bits: set once when a slot is written, cleared only by reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[idx_q[IDX_W-1:0]] <= 1'b1;
		end
	end

	// Walk position: descent for an insert, stackless climb for a traversal.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			dir_q <= abit_pkg::DIR_DOWN;
		end else if (cmd.accept) begin
			idx_q <= '0;
			dir_q <= abit_pkg::DIR_DOWN;
		end else if (cmd.ins_descend) begin
			idx_q <= (key_q < $signed(ram_rdata)) ? left_idx : right_idx;
		end else if (cmd.move) begin
			case (dir_q)
				abit_pkg::DIR_DOWN: begin
					if (left_live) begin
						idx_q <= left_idx;
					end else begin
						dir_q <= abit_pkg::DIR_LEFT_DONE;
					end
				end
				abit_pkg::DIR_LEFT_DONE: begin
					if (right_live) begin
						idx_q <= right_idx;
						dir_q <= abit_pkg::DIR_DOWN;
					end else begin
						dir_q <= abit_pkg::DIR_RIGHT_DONE;
					end
				end
				abit_pkg::DIR_RIGHT_DONE: begin
					idx_q <= parent_idx;
					dir_q <= idx_q[0] ? abit_pkg::DIR_LEFT_DONE : abit_pkg::DIR_RIGHT_DONE;
				end
				default: begin
					dir_q <= abit_pkg::DIR_DOWN;
				end
			endcase
		end
	end

	// Hold buffer: one value is kept back so that the final one can be marked last.
	always_ff @(posedge clk) begin
		if (cmd.emit_take) begin
			pend_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.flush) begin
			pend_vld_q <= 1'b0;
		end else if (cmd.emit_take) begin
			pend_vld_q <= 1'b1;
		end
	end

	// Result register.
	assign out_load = cmd.flush || (cmd.emit_take && pend_vld_q);

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			if (pend_vld_q) begin
				out_q <= '{node_out: pend_q, status: abit_pkg::ST_VALUE, last: 1'b1};
			end else begin
				out_q <= '{node_out: '0, status: res_status_q, last: 1'b1};
			end
		end else if (cmd.emit_take && pend_vld_q) begin
			out_q <= '{node_out: pend_q, status: abit_pkg::ST_VALUE, last: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	// The result register is never overwritten while it still waits for a transfer.
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_vld_q || !result_stall))
		else $error("result register loaded while a result was stalled");

	// Once a slot is valid it stays valid.
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((valid_q & $past(valid_q)) == $past(valid_q)))
		else $error("slot valid bit cleared outside reset");

	// The slot store is written only while an insert is in hand.
	a_write_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (op_q == abit_pkg::OP_INSERT))
		else $error("slot store written during a traversal");

endmodule

// File: src/abit_ctrl.sv
// Controller state machine sequencing inserts, traversal steps and result transfers.
module abit_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  abit_pkg::sts_t sts,
	output abit_pkg::cmd_t cmd
);

	abit_pkg::state_t state_q;
	abit_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abit_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			abit_pkg::S_IDLE: begin
				if (item_valid) begin
					state_d = sts.item_insert ? abit_pkg::S_INS_CHK : abit_pkg::S_VISIT;
				end
			end
			abit_pkg::S_INS_CHK: begin
				state_d = sts.cur_live ? abit_pkg::S_INS_CMP : abit_pkg::S_FLUSH;
			end
			abit_pkg::S_INS_CMP: begin
				state_d = abit_pkg::S_INS_CHK;
			end
			abit_pkg::S_VISIT: begin
				if (sts.empty_root) begin
					state_d = abit_pkg::S_FLUSH;
				end else if (sts.emit_now) begin
					state_d = abit_pkg::S_EMIT;
				end else if (sts.trav_done) begin
					state_d = abit_pkg::S_FLUSH;
				end
			end
			abit_pkg::S_EMIT: begin
				if (!sts.pend_vld || sts.out_free) begin
					state_d = abit_pkg::S_MOVE;
				end
			end
			abit_pkg::S_MOVE: begin
				state_d = sts.trav_done ? abit_pkg::S_FLUSH : abit_pkg::S_VISIT;
			end
			abit_pkg::S_FLUSH: begin
				if (sts.out_free) begin
					state_d = abit_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = abit_pkg::S_IDLE;
			end
		endcase
	end

	// Commands.
	always_comb begin
		cmd        = '0;
		item_stall = 1'b1;
		case (state_q)
			abit_pkg::S_IDLE: begin
				item_stall = 1'b0;
				cmd.accept = item_valid;
			end
			abit_pkg::S_INS_CHK: begin
				cmd.ins_read  = sts.cur_live;
				cmd.ins_write = !sts.cur_live;
			end
			abit_pkg::S_INS_CMP: begin
				cmd.ins_descend = 1'b1;
			end
			abit_pkg::S_VISIT: begin
				if (!sts.empty_root) begin
					if (sts.emit_now) begin
						cmd.emit_read = 1'b1;
					end else if (!sts.trav_done) begin
						cmd.move = 1'b1;
					end
				end
			end
			abit_pkg::S_EMIT: begin
				cmd.emit_take = !sts.pend_vld || sts.out_free;
			end
			abit_pkg::S_MOVE: begin
				cmd.move = !sts.trav_done;
			end
			abit_pkg::S_FLUSH: begin
				cmd.flush = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Every accepted item leaves the idle state at the next edge.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q != abit_pkg::S_IDLE))
		else $error("accepted item did not start work");

	// The closing result is only pushed when the result register can take it.
	a_flush_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flush |-> sts.out_free)
		else $error("closing result pushed into a busy result register");

	// The walk never moves in the cycle that hands a value to the hold buffer.
	a_take_no_move: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_take |-> !cmd.move)
		else $error("walk moved while a value was being taken");

endmodule

// File: src/array_bst_insert_traverse_core.sv
// Top level of the array binary search tree: insert and traversal engine.
//
// Input channel (item_valid, item_stall, item): one transfer carries an op and a
// signed 32-bit key. Op insert walks down from slot 0 (left when the key is
// smaller, right otherwise) and stores the key in the first empty slot. The
// other ops walk the stored tree in in-order, pre-order or post-order.
// Output channel (result_valid, result_stall, result): an insert gives one
// result with status inserted or full; a traversal gives one result per stored
// value, the final one marked last, or a single empty result on an empty tree.
// One item is in work at a time; item_stall is high from acceptance until the
// closing result has been loaded into the result register.
// Insert: each tree level takes a slot read, then a compare and descend, until
// an empty slot or the array end is reached, then the result hand-off follows.
// Traversal: each live slot is passed three times by the walk controller, and
// a value that goes out is first read through the slot store read port and
// then taken into the hold buffer before the walk moves on.
// A value is held back one step so that last can be set on the final one.
// When the receiver stalls, the walk waits with the value in the hold buffer.
// Reset clears all slot valid bits at once, so the tree is empty afterwards.
module array_bst_insert_traverse_core #(
	parameter int TREE_SLOTS = 63
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  abit_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output abit_pkg::result_t result
);

	abit_pkg::cmd_t cmd;
	abit_pkg::sts_t sts;

	// Sequencer.
	abit_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Storage and walk arithmetic.
	abit_datapath #(
		.TREE_SLOTS(TREE_SLOTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.item        (item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// File: test/tb_array_bst_insert_traverse_core.sv
// Self-checking testbench for the array binary search tree insert and traversal core.
module tb_array_bst_insert_traverse_core;

	localparam int SLOTS       = 63;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int PRINT_CAP   = 50;
	localparam int RANDOM_ITEMS = 220;

	// Keeps its own copy of the tree and the queue of results still owed by the block.
	class bst_scoreboard;
		logic signed [abit_pkg::KEY_W-1:0] key_store [SLOTS];
		bit                                key_live  [SLOTS];
		abit_pkg::result_t                 owed_results [$];
		int                                err_count;
		int                                results_seen;

		function new();
			foreach (key_live[i]) begin
				key_live[i]  = 1'b0;
				key_store[i] = '0;
			end
			err_count    = 0;
			results_seen = 0;
		endfunction

		task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
			if (err_count < PRINT_CAP)
				$display("MISMATCH %s: got %h, wanted %h", what, got, want);
			err_count++;
		endtask

		function void owe_value(input logic signed [abit_pkg::KEY_W-1:0] v);
			abit_pkg::result_t r;
			r.node_out = v;
			r.status   = abit_pkg::ST_VALUE;
			r.last     = 1'b0;
			owed_results.push_back(r);
		endfunction

		// Recursive walk of the stored tree in the order the op asks for.
		function void walk_slot(input int idx, input logic [1:0] order);
			if (idx >= SLOTS || !key_live[idx])
				return;
			if (order == abit_pkg::OP_PREORDER)
				owe_value(key_store[idx]);
			walk_slot(2 * idx + 1, order);
			if (order == abit_pkg::OP_INORDER)
				owe_value(key_store[idx]);
			walk_slot(2 * idx + 2, order);
			if (order == abit_pkg::OP_POSTORDER)
				owe_value(key_store[idx]);
		endfunction

		// Works out the results caused by one accepted input transfer.
		function void note_item(input abit_pkg::item_t it);
			int                idx;
			int                before_cnt;
			abit_pkg::result_t r;
			r.node_out = '0;
			r.last     = 1'b1;
			if (it.op == abit_pkg::OP_INSERT) begin
				idx = 0;
				while (idx < SLOTS && key_live[idx]) begin
					if (it.key_value < key_store[idx])
						idx = 2 * idx + 1;
					else
						idx = 2 * idx + 2;
				end
				if (idx < SLOTS) begin
					key_store[idx] = it.key_value;
					key_live[idx]  = 1'b1;
					r.status       = abit_pkg::ST_INSERTED;
				end else begin
					r.status = abit_pkg::ST_FULL;
				end
				owed_results.push_back(r);
			end else begin
				before_cnt = owed_results.size();
				walk_slot(0, it.op);
				if (owed_results.size() == before_cnt) begin
					r.status = abit_pkg::ST_EMPTY;
					owed_results.push_back(r);
				end else begin
					owed_results[owed_results.size() - 1].last = 1'b1;
				end
			end
		endfunction

		// Compares one accepted result transfer with the oldest owed result.
		task check_result(input abit_pkg::result_t got);
			abit_pkg::result_t want;
			results_seen++;
			if (owed_results.size() == 0) begin
				report_mismatch("result with nothing owed", got.node_out, '0);
			end else begin
				want = owed_results.pop_front();
				if (got.node_out !== want.node_out)
					report_mismatch("node_out", got.node_out, want.node_out);
				if (got.status !== want.status)
					report_mismatch("status", 32'(got.status), 32'(want.status));
				if (got.last !== want.last)
					report_mismatch("last", 32'(got.last), 32'(want.last));
			end
		endtask
	endclass

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	abit_pkg::item_t   item         = '0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	abit_pkg::result_t result;

	bst_scoreboard sb;
	int            cycle_count = 0;
	bit            tx_steady   = 1'b0;

	array_bst_insert_traverse_core #(
		.TREE_SLOTS(SLOTS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Clock with a period of two time units.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Cycle count and the overall time limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Both channels are observed at the rising edge, input transfers first.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(item);
			if (result_valid && !result_stall)
				sb.check_result(result);
		end
	end

	// Receiver: random stalls, a quiet window, and one long hold-off.
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(negedge clk) begin
		if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left--;
		end else if (!hold_done && sb.results_seen >= 150) begin
			hold_done = 1'b1;
			hold_left = 400;
			result_stall <= 1'b1;
		end else if (cycle_count >= 2000 && cycle_count < 4000) begin
			result_stall <= 1'b0;
		end else begin
			result_stall <= ($urandom_range(99) < 23);
		end
	end

	// Offers one item and returns at the falling edge after its transfer.
	task automatic send_item(input logic [1:0] op,
			input logic signed [abit_pkg::KEY_W-1:0] key);
		abit_pkg::item_t it;
		it.op        = op;
		it.key_value = key;
		if (!tx_steady) begin
			while ($urandom_range(99) < 23) begin
				item_valid <= 1'b0;
				@(negedge clk);
			end
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Withdraws the offer and waits until every owed result has arrived.
	task automatic wait_drained();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (sb.owed_results.size() != 0);
	endtask

	// Keys biased towards the extremes, small values and duplicates.
	function automatic logic signed [abit_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7FFF_FFFF;
			2:       return -32'sd1;
			3:       return 32'sd0;
			4, 5:    return $signed($urandom_range(64)) - 32'sd32;
			default: return $signed($urandom());
		endcase
	endfunction

	initial begin
		logic [1:0] op;
		sb = new();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Every walk of an empty tree gives a single empty result.
		send_item(abit_pkg::OP_INORDER, $signed($urandom()));
		send_item(abit_pkg::OP_PREORDER, $signed($urandom()));
		send_item(abit_pkg::OP_POSTORDER, $signed($urandom()));

		// Extremes, minus one and duplicates; equal keys go right.
		send_item(abit_pkg::OP_INSERT, 32'sd0);
		send_item(abit_pkg::OP_INSERT, -32'sd1);
		send_item(abit_pkg::OP_INSERT, 32'sh8000_0000);
		send_item(abit_pkg::OP_INSERT, 32'sh7FFF_FFFF);
		send_item(abit_pkg::OP_INSERT, 32'sd0);
		send_item(abit_pkg::OP_INSERT, -32'sd1);
		send_item(abit_pkg::OP_INORDER, 32'sh7FFF_FFFF);
		send_item(abit_pkg::OP_PREORDER, 32'sh8000_0000);
		send_item(abit_pkg::OP_POSTORDER, -32'sd1);

		// Repeated largest key runs down the right edge until the walk leaves the array.
		repeat (5)
			send_item(abit_pkg::OP_INSERT, 32'sh7FFF_FFFF);
		send_item(abit_pkg::OP_INORDER, 32'sd0);
		send_item(abit_pkg::OP_PREORDER, 32'sd0);
		send_item(abit_pkg::OP_POSTORDER, 32'sd0);

		// Random mix, mostly inserts, with a steady stretch and one full drain.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			tx_steady = (n >= 60 && n < 110);
			if (n == 120)
				wait_drained();
			if ($urandom_range(99) < 65)
				op = abit_pkg::OP_INSERT;
			else
				op = 2'($urandom_range(3, 1));
			send_item(op, pick_key());
		end

		wait_drained();
		repeat (100) @(negedge clk);
		if (sb.err_count == 0 && sb.owed_results.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: files.f
src/abit_pkg.sv
src/abit_ram.sv
src/abit_datapath.sv
src/abit_ctrl.sv
src/array_bst_insert_traverse_core.sv
test/tb_array_bst_insert_traverse_core.sv
